@@ hw/rtl/sgrm_pkg.sv @@
// Shared types, constants and register codes for the stereo gain ramp mixer.
// Used by every module of the block; depends on nothing else.
package sgrm_pkg;

  localparam int SAMPLE_WIDTH   = 32;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int WEIGHT_BITS    = 30;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [2:0] REG_SPAN_LENGTH      = 3'd0;
  localparam logic [2:0] REG_FEATHER_WIDTH    = 3'd1;
  localparam logic [2:0] REG_CHANNEL_ENABLE   = 3'd2;
  localparam logic [2:0] REG_START_GAINS_LEFT = 3'd3;
  localparam logic [2:0] REG_END_GAINS_LEFT   = 3'd4;
  localparam logic [2:0] REG_START_GAINS_RIGHT = 3'd5;
  localparam logic [2:0] REG_END_GAINS_RIGHT  = 3'd6;

  localparam logic [0:0] EN_LEFT_BIT  = 1'd0;
  localparam logic [0:0] EN_RIGHT_BIT = 1'd1;

  // Coefficient slots: 0 left->left, 1 right->left, 2 left->right, 3 right->right.
  typedef struct packed {
    logic [31:0]      span;
    logic [19:0]      feather;
    logic [1:0]       en;
    logic [3:0][31:0] gs;
    logic [3:0][31:0] ge;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic [31:0]                    k;
    logic [31:0]                    tail;
  } item_t;

endpackage

@@ hw/rtl/sgrm_front.sv @@
// Front end: accepts sample requests, clamps the offset to the span and
// queues the classified request for the back end. Depends on sgrm_pkg.
module sgrm_front (
  input  logic                clk,
  input  logic                rst,
  input  sgrm_pkg::cfg_t      cfg,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  left_in,
  input  logic signed [31:0]  right_in,
  input  logic [31:0]         sample_offset,
  output logic                q_valid,
  output sgrm_pkg::item_t     q_item,
  input  logic                deq
);
  import sgrm_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [31:0]       n_m1;
  logic [31:0]       k_clamp;
  logic              wr;
  logic              rd;

  // A zero span behaves as a span of one sample.
  assign n_m1    = (cfg.span == 32'd0) ? 32'd0 : cfg.span - 32'd1;
  assign k_clamp = (sample_offset > n_m1) ? n_m1 : sample_offset;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign wr      = push && !full;
  assign rd      = deq && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= '{left: left_in, right: right_in, k: k_clamp, tail: n_m1 - k_clamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

endmodule

@@ hw/rtl/sgrm_div.sv @@
// Pipelined restoring divider: q = floor(a * 2^30 / b) for a <= b, one
// quotient bit per stage. Depends on sgrm_pkg.
module sgrm_div (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [30:0] q
);
  import sgrm_pkg::*;

  localparam int STAGES = WEIGHT_BITS + 1;

  logic [31:0] rem_s [STAGES-1];
  logic [31:0] b_s   [STAGES-1];
  logic [30:0] q_s   [STAGES];
  logic [32:0] diff0;
  logic        ge0;

  assign diff0 = a - {1'b0, b};
  assign ge0   = (a >= {1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= ge0 ? diff0[31:0] : a[31:0];
      b_s[0]   <= b;
      q_s[0]   <= {ge0, 30'd0};
    end
  end

  for (genvar i = 1; i < STAGES; i++) begin : g_stage
    localparam int BIT = WEIGHT_BITS - i;
    logic [32:0] t;
    logic [32:0] sub;
    logic        ge;
    assign t   = {rem_s[i-1], 1'b0};
    assign sub = t - {1'b0, b_s[i-1]};
    assign ge  = (t >= {1'b0, b_s[i-1]});
    always_ff @(posedge clk) begin
      if (en) q_s[i] <= q_s[i-1] | (31'(ge) << BIT);
    end
    if (i < STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[i] <= ge ? sub[31:0] : t[31:0];
          b_s[i]   <= b_s[i-1];
        end
      end
    end
  end

  assign q = q_s[STAGES-1];

endmodule

@@ hw/rtl/sgrm_back.sv @@
// Back end: ratio dividers, coefficient ramp, mix, feather crossfade,
// rounding, saturation and the result register. Depends on sgrm_pkg, sgrm_div.
module sgrm_back (
  input  logic                clk,
  input  logic                rst,
  input  sgrm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  sgrm_pkg::item_t     q_item,
  output logic                deq,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  left_out,
  output logic signed [31:0]  right_out,
  output logic                clipped
);
  import sgrm_pkg::*;

  localparam int DLY   = WEIGHT_BITS + 1;
  localparam int SHIFT = GAIN_FRAC_BITS + WEIGHT_BITS;
  localparam logic [30:0] ONE_Q30 = 31'(1) << WEIGHT_BITS;
  localparam logic signed [99:0] TOP = 100'sd2147483647;
  localparam logic signed [99:0] BOT = -100'sd2147483648;

  function automatic logic signed [99:0] rne(input logic signed [99:0] a, input int s);
    logic signed [99:0] qv;
    logic [99:0]        rem;
    logic [99:0]        half;
    qv   = a >>> s;
    rem  = a & ((100'(1) << s) - 100'(1));
    half = 100'(1) << (s - 1);
    return qv + 100'((rem > half) || ((rem == half) && qv[0]));
  endfunction

  logic adv;
  logic out_valid;

  // Stage 0: operands for both dividers.
  logic              v0;
  logic [32:0]       ra0;
  logic [31:0]       rb0;
  logic [32:0]       fa0;
  logic [31:0]       fb0;
  logic              full0;
  logic signed [31:0] xl0, xr0;
  logic              tail_lt, k_lt;

  // Delay line alongside the dividers.
  logic              vd    [DLY];
  logic              fulld [DLY];
  logic signed [31:0] xld  [DLY];
  logic signed [31:0] xrd  [DLY];
  logic [30:0]       ramp_q, feat_q;

  logic signed [32:0] gdiff [4];

  logic               v1, v2, v3, v4, v5, v6;
  logic signed [63:0] m1_p [4];
  logic [30:0]        m1_f, m2_f, m3_f, m4_f;
  logic signed [31:0] m1_xl, m1_xr, m2_xl, m2_xr, m3_xl, m3_xr;
  logic signed [31:0] m4_xl, m4_xr, m5_xl, m5_xr;
  logic signed [31:0] m2_c [4];
  logic signed [63:0] m3_w [4];
  logic signed [65:0] m4_d [2];
  logic [63:0]        m5_pl [2];
  logic signed [64:0] m5_ph [2];
  logic signed [99:0] m6_acc [2];
  logic signed [31:0] m6_xl, m6_xr;
  logic signed [99:0] vl, vr;
  logic               clip_l, clip_r;

  assign adv   = !out_valid || pop;
  assign deq   = q_valid && adv;
  assign empty = !out_valid;

  assign tail_lt = (q_item.tail < 32'(cfg.feather));
  assign k_lt    = (q_item.k < 32'(cfg.feather));

  always_ff @(posedge clk) begin
    if (adv) begin
      ra0   <= 33'(q_item.k) + 33'd1;
      rb0   <= (cfg.span == 32'd0) ? 32'd1 : cfg.span;
      // The end-of-span rule takes priority over the start rule.
      fa0   <= tail_lt ? 33'(q_item.tail) : 33'(q_item.k);
      fb0   <= 32'(cfg.feather);
      full0 <= (cfg.feather == 20'd0) || (!tail_lt && !k_lt);
      xl0   <= q_item.left;
      xr0   <= q_item.right;
    end
  end

  sgrm_div u_ramp_div (.clk(clk), .en(adv), .a(ra0), .b(rb0), .q(ramp_q));
  sgrm_div u_feat_div (.clk(clk), .en(adv), .a(fa0), .b(fb0), .q(feat_q));

  always_ff @(posedge clk) begin
    if (adv) begin
      fulld[0] <= full0;
      xld[0]   <= xl0;
      xrd[0]   <= xr0;
      for (int i = 1; i < DLY; i++) begin
        fulld[i] <= fulld[i-1];
        xld[i]   <= xld[i-1];
        xrd[i]   <= xrd[i-1];
      end
    end
  end

  // User must change gains only while idle (unchecked); slopes are registered.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      gdiff[i] <= 33'($signed(cfg.ge[i])) - 33'($signed(cfg.gs[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        m1_p[i] <= 64'(gdiff[i]) * 64'($signed({1'b0, ramp_q}));
      end
      m1_f  <= fulld[DLY-1] ? ONE_Q30 : feat_q;
      m1_xl <= xld[DLY-1];
      m1_xr <= xrd[DLY-1];

      for (int i = 0; i < 4; i++) begin
        m2_c[i] <= 32'(rne((100'($signed(cfg.gs[i])) <<< WEIGHT_BITS) + 100'(m1_p[i]),
                           WEIGHT_BITS));
      end
      m2_f  <= m1_f;
      m2_xl <= m1_xl;
      m2_xr <= m1_xr;

      m3_w[0] <= 64'(m2_xl) * 64'(m2_c[0]);
      m3_w[1] <= 64'(m2_xr) * 64'(m2_c[1]);
      m3_w[2] <= 64'(m2_xl) * 64'(m2_c[2]);
      m3_w[3] <= 64'(m2_xr) * 64'(m2_c[3]);
      m3_f  <= m2_f;
      m3_xl <= m2_xl;
      m3_xr <= m2_xr;

      // Wet minus dry, both in Q.24.
      m4_d[0] <= 66'(m3_w[0]) + 66'(m3_w[1]) - (66'(m3_xl) <<< GAIN_FRAC_BITS);
      m4_d[1] <= 66'(m3_w[2]) + 66'(m3_w[3]) - (66'(m3_xr) <<< GAIN_FRAC_BITS);
      m4_f  <= m3_f;
      m4_xl <= m3_xl;
      m4_xr <= m3_xr;

      // The wide difference is multiplied by the feather weight in two halves.
      for (int j = 0; j < 2; j++) begin
        m5_pl[j] <= 64'(m4_d[j][32:0]) * 64'(m4_f);
        m5_ph[j] <= 65'($signed(m4_d[j][65:33])) * 65'($signed({1'b0, m4_f}));
      end
      m5_xl <= m4_xl;
      m5_xr <= m4_xr;

      m6_acc[0] <= (100'(m5_xl) <<< SHIFT) + (100'(m5_ph[0]) <<< 33)
                   + $signed(100'(m5_pl[0]));
      m6_acc[1] <= (100'(m5_xr) <<< SHIFT) + (100'(m5_ph[1]) <<< 33)
                   + $signed(100'(m5_pl[1]));
      m6_xl <= m5_xl;
      m6_xr <= m5_xr;
    end
  end

  assign vl     = rne(m6_acc[0], SHIFT);
  assign vr     = rne(m6_acc[1], SHIFT);
  assign clip_l = (vl > TOP) || (vl < BOT);
  assign clip_r = (vr > TOP) || (vr < BOT);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cfg.en[EN_LEFT_BIT]) begin
        left_out <= (vl > TOP) ? TOP[31:0] : ((vl < BOT) ? BOT[31:0] : vl[31:0]);
      end else begin
        left_out <= m6_xl;
      end
      if (cfg.en[EN_RIGHT_BIT]) begin
        right_out <= (vr > TOP) ? TOP[31:0] : ((vr < BOT) ? BOT[31:0] : vr[31:0]);
      end else begin
        right_out <= m6_xr;
      end
      clipped <= (cfg.en[EN_LEFT_BIT] && clip_l) || (cfg.en[EN_RIGHT_BIT] && clip_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < DLY; i++) vd[i] <= 1'b0;
    end else if (adv) begin
      v0 <= q_valid;
      vd[0] <= v0;
      for (int i = 1; i < DLY; i++) vd[i] <= vd[i-1];
      v1        <= vd[DLY-1];
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v6) && $stable(vd[DLY-1]))
    else $error("pipeline moved while the result register was blocked");

  a_ramp_le_one: assert property (@(posedge clk) disable iff (rst)
    vd[DLY-1] |-> (ramp_q <= ONE_Q30))
    else $error("ramp weight above one");

  a_clip_enabled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (cfg.en != 2'b00))
    else $error("clip flagged with both channels bypassed");

endmodule

@@ hw/rtl/stereo_gain_ramp_mixer.sv @@
// Stereo gain ramp mixer: a 2x2 mix with ramped gains, crossfaded at span ends.
// Throughput: one sample pair per cycle while the output is empty or popped,
// set by the fully pipelined dividers, multipliers and round stages; a 4-entry
// queue parts front and back.
// Reset (synchronous, rst high) empties both ends and loads the default registers.
module stereo_gain_ramp_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] left_in,
  input  logic signed [31:0] right_in,
  input  logic [31:0]        sample_offset,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] left_out,
  output logic signed [31:0] right_out,
  output logic               clipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import sgrm_pkg::*;

  logic [31:0] span_length;
  logic [19:0] fade_width;
  logic [1:0]  channel_enable;
  logic [63:0] start_gains_from_left;
  logic [63:0] end_gains_from_left;
  logic [63:0] start_gains_from_right;
  logic [63:0] end_gains_from_right;

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  deq;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_length            <= 32'd1;
      fade_width             <= 20'd20;
      channel_enable         <= 2'd3;
      start_gains_from_left  <= 64'h0100_0000_0000_0000;
      end_gains_from_left    <= 64'h0100_0000_0000_0000;
      start_gains_from_right <= 64'h0000_0000_0100_0000;
      end_gains_from_right   <= 64'h0000_0000_0100_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPAN_LENGTH:       span_length            <= cfg_data[31:0];
        REG_FEATHER_WIDTH:     fade_width             <= cfg_data[19:0];
        REG_CHANNEL_ENABLE:    channel_enable         <= cfg_data[1:0];
        REG_START_GAINS_LEFT:  start_gains_from_left  <= cfg_data;
        REG_END_GAINS_LEFT:    end_gains_from_left    <= cfg_data;
        REG_START_GAINS_RIGHT: start_gains_from_right <= cfg_data;
        REG_END_GAINS_RIGHT:   end_gains_from_right   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Upper gain halves feed the left output, lower halves the right output.
  assign cfg.span    = span_length;
  assign cfg.feather = fade_width;
  assign cfg.en      = channel_enable;
  assign cfg.gs[0]   = start_gains_from_left[63:32];
  assign cfg.gs[1]   = start_gains_from_right[63:32];
  assign cfg.gs[2]   = start_gains_from_left[31:0];
  assign cfg.gs[3]   = start_gains_from_right[31:0];
  assign cfg.ge[0]   = end_gains_from_left[63:32];
  assign cfg.ge[1]   = end_gains_from_right[63:32];
  assign cfg.ge[2]   = end_gains_from_left[31:0];
  assign cfg.ge[3]   = end_gains_from_right[31:0];

  sgrm_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .push(push), .full(full),
    .left_in(left_in), .right_in(right_in), .sample_offset(sample_offset),
    .q_valid(q_valid), .q_item(q_item), .deq(deq)
  );

  sgrm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .deq(deq),
    .pop(pop), .empty(empty),
    .left_out(left_out), .right_out(right_out), .clipped(clipped)
  );

endmodule
